// ===== rtl/cde_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cde_pkg: shared types and codes of the circular deque engine
// Operation and status codes, and the widths of their fields.
// ----------------------------------------------------------------------------
package cde_pkg;

   localparam int FuncWidth   = 4;
   localparam int StatusWidth = 2;

   typedef enum logic [3:0] {
      FN_PUSH_TAIL  = 4'd0,
      FN_PUSH_HEAD  = 4'd1,
      FN_POP_TAIL   = 4'd2,
      FN_POP_HEAD   = 4'd3,
      FN_READ       = 4'd4,
      FN_WRITE      = 4'd5,
      FN_INSERT     = 4'd6,
      FN_ERASE      = 4'd7,
      FN_CLEAR      = 4'd8
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/cde_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cde_ram: generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module cde_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Storage array with registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule
`default_nettype wire

// ===== rtl/circular_deque_engine_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// circular_deque_engine_unit: double-ended queue in a circular store
// Push and pop at either end, indexed read, write, insert, erase and clear.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy rises the next
// cycle and stays up until the result strobe. The receiver cannot stall:
// each result is on the rsp_ ports for exactly one cycle while rsp_valid is
// high. Every item goes through one single-port store, so its length is set
// by store accesses: status-only items make none, pushes and writes one write,
// pops and reads one read, and insert and erase one access of their own and
// k element moves, k at most CAPACITY/2 (each move is a read and a write on
// the one port). A one-entry command queue sits between the front part,
// which checks the item, and the back part, which runs the store.
// ----------------------------------------------------------------------------
module circular_deque_engine_unit #(
   parameter int CAPACITY   = 32,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [cde_pkg::FuncWidth-1:0]   req_func,
   input  wire logic [5:0]                      req_position,
   input  wire logic [31:0]                     req_value,
   output logic                                 rsp_valid,
   output logic [31:0]                          rsp_read_data,
   output logic [5:0]                           rsp_count,
   output logic [cde_pkg::StatusWidth-1:0]      rsp_status
);
   import cde_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > 6) ? CW : 6;
   localparam logic [CW-1:0] CapC = CW'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE, S_QUEUED, S_READ, S_MOVE_RD, S_MOVE_WR, S_FINAL_WR, S_DONE
   } state_type;

   state_type       state_ff, state_in;
   logic [AW-1:0]   head_ff, head_in;
   logic [CW-1:0]   count_ff, count_in;
   // Queued command.
   func_type        func_ff, func_in;
   logic [CW-1:0]   pos_ff, pos_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic            ok_ff, ok_in;
   status_type      st_ff, st_in;
   logic            back_ff, back_in;      // move toward back side
   logic [CW-1:0]   idx_ff, idx_in;        // current logical index while moving
   logic [CW-1:0]   stop_ff, stop_in;
   logic [DATA_WIDTH-1:0] rd_ff, rd_in;
   logic            rv_ff, rv_in;

   logic                  wr_en;
   logic [AW-1:0]         addr;
   logic [DATA_WIDTH-1:0] wr_data, ram_q;
   logic [CW-1:0]         lidx;

   cde_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_ram (
      .clock(clock), .wr_en(wr_en), .addr(addr), .wr_data(wr_data), .rd_data(ram_q)
   );

   // Map a logical index to a physical slot, modulo CAPACITY.
   function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] l);
      logic [CW:0] s;
      s = {{(CW+1-AW){1'b0}}, h} + {1'b0, l};
      if (s >= {1'b0, CapC}) s = s - {1'b0, CapC};
      return s[AW-1:0];
   endfunction

   logic [PW-1:0] pos_w;
   logic [CW-1:0] pos_c;
   logic          pos_big;
   assign pos_w   = PW'(req_position);
   assign pos_c   = pos_w[CW-1:0];
   assign pos_big = (PW > CW) ? (pos_w >> CW) != '0 : 1'b0;

   assign busy = (state_ff != S_IDLE);

   // Front part: classify the item and fill the command queue.
   // Back part: the sequencer that runs the store.
   always_comb begin
      state_in = state_ff; head_in = head_ff; count_in = count_ff;
      func_in = func_ff; pos_in = pos_ff; val_in = val_ff; ok_in = ok_ff; st_in = st_ff;
      back_in = back_ff; idx_in = idx_ff; stop_in = stop_ff; rd_in = rd_ff;
      rv_in = 1'b0;
      wr_en = 1'b0; lidx = '0; wr_data = val_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in = func_type'(req_func);
               pos_in  = pos_c;
               val_in  = req_value[DATA_WIDTH-1:0];
               rd_in   = '0;
               st_in   = ST_OK;
               ok_in   = 1'b1;
               case (req_func)
                  FN_PUSH_TAIL, FN_PUSH_HEAD:
                     if (count_ff == CapC) begin st_in = ST_FULL; ok_in = 1'b0; end
                  FN_POP_TAIL, FN_POP_HEAD:
                     if (count_ff == '0) begin st_in = ST_EMPTY; ok_in = 1'b0; end
                  FN_READ, FN_ERASE:
                     if (count_ff == '0) begin st_in = ST_EMPTY; ok_in = 1'b0; end
                     else if (pos_big || pos_c >= count_ff) begin
                        st_in = ST_RANGE; ok_in = 1'b0;
                     end
                  FN_WRITE:
                     if (pos_big || pos_c >= count_ff) begin
                        st_in = ST_RANGE; ok_in = 1'b0;
                     end
                  FN_INSERT:
                     if (count_ff == CapC) begin st_in = ST_FULL; ok_in = 1'b0; end
                     else if (pos_big || pos_c > count_ff) begin
                        st_in = ST_RANGE; ok_in = 1'b0;
                     end
                  default: ok_in = 1'b1;
               endcase
               state_in = S_QUEUED;
            end
         end
         S_QUEUED: begin
            state_in = S_DONE;
            if (ok_ff) begin
               case (func_ff)
                  FN_PUSH_TAIL: begin
                     wr_en = 1'b1; lidx = count_ff; count_in = count_ff + 1'b1;
                  end
                  FN_PUSH_HEAD: begin
                     head_in = slot(head_ff, CapC - 1'b1);
                     wr_en = 1'b1; lidx = CapC - 1'b1; count_in = count_ff + 1'b1;
                  end
                  FN_POP_TAIL: begin
                     lidx = count_ff - 1'b1; count_in = count_ff - 1'b1; state_in = S_READ;
                  end
                  FN_POP_HEAD: begin
                     lidx = '0; head_in = slot(head_ff, CW'(1));
                     count_in = count_ff - 1'b1; state_in = S_READ;
                  end
                  FN_READ: begin lidx = pos_ff; state_in = S_READ; end
                  FN_WRITE: begin wr_en = 1'b1; lidx = pos_ff; end
                  FN_INSERT: begin
                     if (pos_ff >= (count_ff >> 1)) begin
                        back_in = 1'b1; idx_in = count_ff; stop_in = pos_ff;
                     end else begin
                        back_in = 1'b0; head_in = slot(head_ff, CapC - 1'b1);
                        idx_in = '0; stop_in = pos_ff;
                     end
                     count_in = count_ff + 1'b1;
                     state_in = S_MOVE_RD;
                  end
                  FN_ERASE: begin
                     lidx = pos_ff; state_in = S_READ;
                  end
                  FN_CLEAR: begin head_in = '0; count_in = '0; end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_READ: begin
            rd_in = ram_q;
            state_in = S_DONE;
            if (func_ff == FN_ERASE) begin
               if (pos_ff >= (count_ff >> 1)) begin
                  back_in = 1'b1; idx_in = pos_ff; stop_in = count_ff - 1'b1;
               end else begin
                  back_in = 1'b0; idx_in = pos_ff; stop_in = '0;
               end
               state_in = S_MOVE_RD;
            end
         end
         S_MOVE_RD: begin
            // Insert: back side moves i-1 -> i down to pos; front side i+1 -> i up to pos.
            // Erase: back side moves i+1 -> i up to count-1; front side i-1 -> i down to 0.
            if (idx_ff == stop_ff) begin
               if (func_ff == FN_INSERT) begin
                  state_in = S_FINAL_WR;
               end else begin
                  if (!back_ff) head_in = slot(head_ff, CW'(1));
                  count_in = count_ff - 1'b1;
                  state_in = S_DONE;
               end
            end else begin
               if ((func_ff == FN_INSERT) == back_ff) lidx = idx_ff - 1'b1;
               else lidx = idx_ff + 1'b1;
               state_in = S_MOVE_WR;
            end
         end
         S_MOVE_WR: begin
            wr_en = 1'b1; lidx = idx_ff; wr_data = ram_q;
            idx_in = ((func_ff == FN_INSERT) == back_ff) ? idx_ff - 1'b1 : idx_ff + 1'b1;
            state_in = S_MOVE_RD;
         end
         S_FINAL_WR: begin
            wr_en = 1'b1; lidx = pos_ff; state_in = S_DONE;
         end
         S_DONE: begin
            rv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      addr = slot(head_ff, lidx);
   end

   // State, pointers and registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; head_ff <= '0; count_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; head_ff <= head_in; count_ff <= count_in; rv_ff <= rv_in;
      end
      func_ff <= func_in; pos_ff <= pos_in; val_ff <= val_in; ok_ff <= ok_in;
      st_ff <= st_in; back_ff <= back_in; idx_ff <= idx_in; stop_ff <= stop_in;
      rd_ff <= rd_in;
   end

   assign rsp_valid     = rv_ff;
   assign rsp_read_data = 32'(rd_ff);
   assign rsp_count     = 6'(count_ff);
   assign rsp_status    = st_ff;

endmodule
`default_nettype wire
